### hdl/rfid_frame_check_and_card_match_core_assert.svh
// assertion macros shared by the rfid frame checker modules
// all macros sample on clk and are disabled while rst_n is low
`ifndef RFID_FRAME_CHECK_AND_CARD_MATCH_CORE_ASSERT_SVH
`define RFID_FRAME_CHECK_AND_CARD_MATCH_CORE_ASSERT_SVH

// condition must never hold at a clock edge
`define RFC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rfc assertion failed: forbidden condition");

// antecedent at one edge implies consequent at the next edge
`define RFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfc assertion failed: next-cycle implication");

`endif

### hdl/rfc_pkg.sv
package rfc_pkg;

  // frame layout
  localparam int unsigned FRAME_BYTES = 13;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned LAST_POS    = FRAME_BYTES - 1;
  localparam int unsigned CHK_POS     = FRAME_BYTES - 2;
  localparam int unsigned ALLOWED_CNT = 7;
  localparam int unsigned CFG_IDX_W   = 3;

  // marker and command bytes
  localparam logic [7:0] LEN_BYTE    = 8'h0D;
  localparam logic [7:0] END_BYTE    = 8'h55;
  localparam logic [7:0] LEAVE_CMD0  = 8'h01;
  localparam logic [7:0] LEAVE_CMD2  = 8'hA6;
  localparam logic [7:0] READ_CMD0   = 8'h04;
  localparam logic [7:0] READ_CMD2   = 8'h02;

  // allowed id reset values
  localparam logic [31:0] ALLOWED_RST [ALLOWED_CNT] = '{
    32'h341105E3, 32'h540E07E3, 32'hC4FE03E3, 32'h24D189E2,
    32'h44C1EBE9, 32'h449D56EB, 32'hB4C80FE3
  };

  // frame action decided by the front end
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_LEAVE = 2'd1,
    ACT_READ  = 2'd2
  } act_t;

  // event codes on the result word
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_LEAVE = 2'd1,
    EV_REACH = 2'd2
  } ev_t;

  // classified frame passed from front to back
  typedef struct packed {
    act_t        act;
    logic [15:0] kind;
    logic [31:0] number;
  } frame_desc_t;

endpackage

### hdl/rfc_front.sv
module rfc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  output logic                push,
  output rfc_pkg::frame_desc_t push_desc,
  input  logic                full
);
  import rfc_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [7:0]       frame_r [LAST_POS];
  logic             last_byte;
  logic             accept;
  logic             valid_frame;

  assign last_byte = (pos_r == POS_W'(LAST_POS));
  // a byte that closes a frame needs room in the queue
  assign in_ready  = !last_byte || !full;
  assign accept    = in_valid && in_ready;
  assign push      = accept && last_byte;

  // position and running checksum
  always_comb begin
    pos_nxt = pos_r;
    xor_nxt = xor_r;
    if (accept) begin
      if (last_byte) begin
        pos_nxt = '0;
        xor_nxt = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        if (pos_r < POS_W'(CHK_POS)) begin
          xor_nxt = xor_r ^ in_rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      xor_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      xor_r <= xor_nxt;
    end
  end

  // frame byte capture
  always_ff @(posedge clk) begin
    if (accept && !last_byte) begin
      frame_r[pos_r] <= in_rx_byte;
    end
  end

  // classify on the end byte
  assign valid_frame = (frame_r[1] == LEN_BYTE) && (in_rx_byte == END_BYTE) &&
                       (frame_r[CHK_POS] == ~xor_r);

  always_comb begin
    push_desc.kind   = {frame_r[5], frame_r[6]};
    push_desc.number = {frame_r[7], frame_r[8], frame_r[9], frame_r[10]};
    if (!valid_frame) begin
      push_desc.act = ACT_NONE;
    end else if (frame_r[0] == LEAVE_CMD0 && frame_r[2] == LEAVE_CMD2) begin
      push_desc.act = ACT_LEAVE;
    end else if (frame_r[0] == READ_CMD0 && frame_r[2] == READ_CMD2) begin
      push_desc.act = ACT_READ;
    end else begin
      push_desc.act = ACT_LEAVE;
    end
  end

endmodule

### hdl/rfc_fifo.sv
`include "rfid_frame_check_and_card_match_core_assert.svh"

module rfc_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rfc_pkg::frame_desc_t push_desc,
  output logic                 full,
  input  logic                 pop,
  output rfc_pkg::frame_desc_t pop_desc,
  output logic                 not_empty
);
  import rfc_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  frame_desc_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_desc  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // descriptor storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  `RFC_ASSERT_NEVER(a_no_push_full, push && full)
  `RFC_ASSERT_NEVER(a_no_pop_empty, pop && !not_empty)
  `RFC_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + CNT_W'(1))
  `RFC_ASSERT_NEXT(a_cnt_down, pop && !push, cnt_r == $past(cnt_r) - CNT_W'(1))

endmodule

### hdl/rfc_back.sv
module rfc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          desc_valid,
  input  rfc_pkg::frame_desc_t          desc,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_frame_valid,
  output logic [1:0]                    out_event_code,
  output logic                          out_indicator_level,
  output logic [15:0]                   out_card_kind,
  output logic [31:0]                   out_card_number
);
  import rfc_pkg::*;

  logic [31:0]  allowed_r [ALLOWED_CNT];
  logic [ALLOWED_CNT-1:0] hit;
  logic         ind_r, ind_nxt;
  logic [15:0]  kind_r, kind_nxt;
  logic [31:0]  num_r, num_nxt;
  ev_t          ev_nxt;
  logic         out_valid_r;
  logic         fv_r;
  ev_t          ev_r;

  assign cfg_ready = 1'b1;

  // allowed id registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALLOWED_CNT; i++) begin
        allowed_r[i] <= ALLOWED_RST[i];
      end
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(ALLOWED_CNT)) begin
      allowed_r[cfg_index] <= cfg_data;
    end
  end

  // id compare lanes
  always_comb begin
    for (int i = 0; i < ALLOWED_CNT; i++) begin
      hit[i] = (allowed_r[i] == desc.number);
    end
  end

  assign pop = desc_valid && (!out_valid_r || out_ready);

  // apply frame action to indicator and card latches
  always_comb begin
    ind_nxt  = ind_r;
    kind_nxt = kind_r;
    num_nxt  = num_r;
    ev_nxt   = EV_NONE;
    unique case (desc.act)
      ACT_LEAVE: begin
        ev_nxt  = EV_LEAVE;
        ind_nxt = 1'b1;
      end
      ACT_READ: begin
        kind_nxt = desc.kind;
        num_nxt  = desc.number;
        if (|hit) begin
          ev_nxt  = EV_REACH;
          ind_nxt = 1'b0;
        end
      end
      default: begin
        ev_nxt = EV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ind_r       <= 1'b0;
      kind_r      <= '0;
      num_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        ind_r       <= ind_nxt;
        kind_r      <= kind_nxt;
        num_r       <= num_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word status fields
  always_ff @(posedge clk) begin
    if (pop) begin
      fv_r <= (desc.act != ACT_NONE);
      ev_r <= ev_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_valid     = fv_r;
  assign out_event_code      = ev_r;
  assign out_indicator_level = ind_r;
  assign out_card_kind       = kind_r;
  assign out_card_number     = num_r;

endmodule

### hdl/rfid_frame_check_and_card_match_core.sv
// a frame is queued as its 13th byte is accepted; its result turns valid as it is popped
// throughput: one byte per cycle while in_ready is high; one result word per 13 bytes,
// set by the byte counter; the front end stalls only on a frame end byte while the
// 2-deep frame queue is full. reset (rst_n low, synchronous): byte count, checksum,
// queue, indicator and card latches clear; allowed ids return to their default values
module rfid_frame_check_and_card_match_core #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_frame_valid,
  output logic [1:0]                    out_event_code,
  output logic                          out_indicator_level,
  output logic [15:0]                   out_card_kind,
  output logic [31:0]                   out_card_number,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import rfc_pkg::*;

  logic        push;
  logic        full;
  logic        pop;
  logic        not_empty;
  frame_desc_t push_desc;
  frame_desc_t pop_desc;

  // byte counting and frame classification
  rfc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .push       (push),
    .push_desc  (push_desc),
    .full       (full)
  );

  // classified frame queue
  rfc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .full      (full),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .not_empty (not_empty)
  );

  // id match, state update and result word
  rfc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .desc_valid          (not_empty),
    .desc                (pop_desc),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_valid     (out_frame_valid),
    .out_event_code      (out_event_code),
    .out_indicator_level (out_indicator_level),
    .out_card_kind       (out_card_kind),
    .out_card_number     (out_card_number)
  );

endmodule
